### sv/atr_trailing_stop_signal_defines.svh
// Assertion macros for the trailing stop block.
`ifndef ATR_TRAILING_STOP_SIGNAL_DEFINES_SVH
`define ATR_TRAILING_STOP_SIGNAL_DEFINES_SVH
`ifndef SYNTHESIS
`define ATR_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("atr check failed");
`define ATR_ASSERT_RST(label, clk, prop) \
	label: assert property (@(posedge clk) prop) \
		else $error("atr reset check failed");
`else
`define ATR_ASSERT(label, clk, rst_n, prop)
`define ATR_ASSERT_RST(label, clk, prop)
`endif
`endif

### sv/atr_pkg.sv
package atr_pkg;

	localparam int PRICE_BITS_DEF    = 24;
	localparam int FRACTION_BITS_DEF = 8;

	localparam int STOP_W   = 38;
	localparam int ATR_W    = 32;
	localparam int MULT_W   = 4;
	localparam int PERIOD_W = 8;
	localparam int NLOSS_W  = ATR_W + MULT_W;
	localparam int DATA_W   = 32;
	localparam int ADDR_W   = 4;
	localparam int IDX_W    = 2;

	localparam logic [IDX_W-1:0] REG_MULT   = 2'd0;
	localparam logic [IDX_W-1:0] REG_PERIOD = 2'd1;
	localparam logic [IDX_W-1:0] REG_AVG    = 2'd2;

	localparam logic [MULT_W-1:0]   MULT_RESET   = 4'd1;
	localparam logic [PERIOD_W-1:0] PERIOD_RESET = 8'd10;

	typedef struct packed {
		logic latch;
		logic prep;
		logic load;
		logic div_step;
		logic atr;
		logic nloss;
		logic stop;
	} atr_cmd_t;

	typedef struct packed {
		logic need_div;
		logic div_done;
	} atr_status_t;

endpackage

### sv/atr_trailing_stop_signal.sv
// ATR trailing stop with crossover buy and sell signals.
// Input channel: in_valid / in_stall carries one price bar per word
// (open_price, high_price, low_price, close_price, unsigned ticks).
// Output channel: out_valid / out_stall carries one result word per bar:
// stop_level (signed, 8 fraction bits by default), range_average, stop_valid,
// buy_cross, sell_cross, price_above, price_below.
// Configuration through the APB port: multiplier at 0x0, period at 0x4,
// averaged candle mode at 0x8; write only while no bar is in flight.
// Warm-up bars (before the ATR is formed) pass through the prep and stop
// states only and give an all-zero word. Other bars go on from prep to a
// load step and a bit-serial divider by the period over DIV_W bits, where
// DIV_W = max(PRICE_BITS + 8 + FRACTION_BITS, 41), then to the ATR, loss
// and stop steps. One bar is processed at a time.
// The result sits in an output register; while out_stall is high it holds
// and the block waits before writing the next result.
// Reset clears the ATR state, the stop and the output valid, and restores
// multiplier 1, period 10 and close-price source.
module atr_trailing_stop_signal #(
	parameter int PRICE_BITS    = atr_pkg::PRICE_BITS_DEF,
	parameter int FRACTION_BITS = atr_pkg::FRACTION_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [atr_pkg::ADDR_W-1:0]        paddr,
	input  logic [atr_pkg::DATA_W-1:0]        pwdata,
	output logic [atr_pkg::DATA_W-1:0]        prdata,
	output logic                              pready,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [PRICE_BITS-1:0]             open_price,
	input  logic [PRICE_BITS-1:0]             high_price,
	input  logic [PRICE_BITS-1:0]             low_price,
	input  logic [PRICE_BITS-1:0]             close_price,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [atr_pkg::STOP_W-1:0] stop_level,
	output logic [atr_pkg::ATR_W-1:0]         range_average,
	output logic                              stop_valid,
	output logic                              buy_cross,
	output logic                              sell_cross,
	output logic                              price_above,
	output logic                              price_below
);

	atr_pkg::atr_cmd_t              cmd;
	atr_pkg::atr_status_t           status;
	logic [atr_pkg::MULT_W-1:0]     atr_multiplier;
	logic [atr_pkg::PERIOD_W-1:0]   period_len;
	logic                           averaged_candle_mode;

	atr_regs u_regs (
		.clk                  (clk),
		.arst_n               (arst_n),
		.psel                 (psel),
		.penable              (penable),
		.pwrite               (pwrite),
		.paddr                (paddr),
		.pwdata               (pwdata),
		.prdata               (prdata),
		.pready               (pready),
		.atr_multiplier       (atr_multiplier),
		.period_len           (period_len),
		.averaged_candle_mode (averaged_candle_mode)
	);

	atr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd)
	);

	atr_dp #(
		.PRICE_BITS    (PRICE_BITS),
		.FRACTION_BITS (FRACTION_BITS)
	) u_dp (
		.clk                  (clk),
		.arst_n               (arst_n),
		.cmd                  (cmd),
		.status               (status),
		.atr_multiplier       (atr_multiplier),
		.period_len           (period_len),
		.averaged_candle_mode (averaged_candle_mode),
		.open_price           (open_price),
		.high_price           (high_price),
		.low_price            (low_price),
		.close_price          (close_price),
		.stop_level           (stop_level),
		.range_average        (range_average),
		.stop_valid           (stop_valid),
		.buy_cross            (buy_cross),
		.sell_cross           (sell_cross),
		.price_above          (price_above),
		.price_below          (price_below)
	);

endmodule

### sv/atr_regs.sv
module atr_regs (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [atr_pkg::ADDR_W-1:0]      paddr,
	input  logic [atr_pkg::DATA_W-1:0]      pwdata,
	output logic [atr_pkg::DATA_W-1:0]      prdata,
	output logic                            pready,
	output logic [atr_pkg::MULT_W-1:0]      atr_multiplier,
	output logic [atr_pkg::PERIOD_W-1:0]    period_len,
	output logic                            averaged_candle_mode
);

	logic [atr_pkg::MULT_W-1:0]   mult_q;
	logic [atr_pkg::PERIOD_W-1:0] period_q;
	logic                         avg_q;
	logic [atr_pkg::IDX_W-1:0]    idx;
	logic                         wr;

	assign idx    = paddr[atr_pkg::ADDR_W-1:2];
	assign wr     = psel && penable && pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mult_q   <= atr_pkg::MULT_RESET;
			period_q <= atr_pkg::PERIOD_RESET;
			avg_q    <= 1'b0;
		end else if (wr) begin
			case (idx)
				atr_pkg::REG_MULT:   mult_q   <= pwdata[atr_pkg::MULT_W-1:0];
				atr_pkg::REG_PERIOD: period_q <= pwdata[atr_pkg::PERIOD_W-1:0];
				atr_pkg::REG_AVG:    avg_q    <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			atr_pkg::REG_MULT:   prdata = atr_pkg::DATA_W'(mult_q);
			atr_pkg::REG_PERIOD: prdata = atr_pkg::DATA_W'(period_q);
			atr_pkg::REG_AVG:    prdata = atr_pkg::DATA_W'(avg_q);
			default:             prdata = '0;
		endcase
	end

	assign atr_multiplier       = mult_q;
	assign period_len           = period_q;
	assign averaged_candle_mode = avg_q;

endmodule

### sv/atr_ctrl.sv
`include "atr_trailing_stop_signal_defines.svh"

module atr_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	output logic                 out_valid,
	input  logic                 out_stall,
	input  atr_pkg::atr_status_t status,
	output atr_pkg::atr_cmd_t    cmd
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_PREP  = 3'd1;
	localparam logic [2:0] S_LOAD  = 3'd2;
	localparam logic [2:0] S_DIV   = 3'd3;
	localparam logic [2:0] S_ATR   = 3'd4;
	localparam logic [2:0] S_NLOSS = 3'd5;
	localparam logic [2:0] S_STOP  = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       out_valid_q;
	logic       out_free;

	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd          = '0;
		state_d      = state_q;
		cmd.latch    = (state_q == S_IDLE) && in_valid;
		cmd.prep     = (state_q == S_PREP);
		cmd.load     = (state_q == S_LOAD);
		cmd.div_step = (state_q == S_DIV);
		cmd.atr      = (state_q == S_ATR);
		cmd.nloss    = (state_q == S_NLOSS);
		cmd.stop     = (state_q == S_STOP) && out_free;
		case (state_q)
			S_IDLE:  if (in_valid) state_d = S_PREP;
			S_PREP:  state_d = status.need_div ? S_LOAD : S_STOP;
			S_LOAD:  state_d = S_DIV;
			S_DIV:   if (status.div_done) state_d = S_ATR;
			S_ATR:   state_d = S_NLOSS;
			S_NLOSS: state_d = S_STOP;
			S_STOP:  if (out_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.stop) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	`ATR_ASSERT(a_accept_prep, clk, arst_n, (in_valid && !in_stall) |=> (state_q == S_PREP))
	`ATR_ASSERT(a_word_from_stop, clk, arst_n, $rose(out_valid_q) |-> $past(state_q == S_STOP))
	`ATR_ASSERT(a_div_exit, clk, arst_n, (state_q == S_DIV && status.div_done) |=> (state_q == S_ATR))
	`ATR_ASSERT_RST(a_reset_idle, clk, (!arst_n) |-> (state_q == S_IDLE && !out_valid_q))

endmodule

### sv/atr_dp.sv
module atr_dp #(
	parameter int PRICE_BITS    = atr_pkg::PRICE_BITS_DEF,
	parameter int FRACTION_BITS = atr_pkg::FRACTION_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  atr_pkg::atr_cmd_t                 cmd,
	output atr_pkg::atr_status_t              status,
	input  logic [atr_pkg::MULT_W-1:0]        atr_multiplier,
	input  logic [atr_pkg::PERIOD_W-1:0]      period_len,
	input  logic                              averaged_candle_mode,
	input  logic [PRICE_BITS-1:0]             open_price,
	input  logic [PRICE_BITS-1:0]             high_price,
	input  logic [PRICE_BITS-1:0]             low_price,
	input  logic [PRICE_BITS-1:0]             close_price,
	output logic signed [atr_pkg::STOP_W-1:0] stop_level,
	output logic [atr_pkg::ATR_W-1:0]         range_average,
	output logic                              stop_valid,
	output logic                              buy_cross,
	output logic                              sell_cross,
	output logic                              price_above,
	output logic                              price_below
);

	localparam int PW      = atr_pkg::PERIOD_W;
	localparam int SRC_W   = PRICE_BITS + FRACTION_BITS;
	localparam int SUM_W   = PRICE_BITS + PW;
	localparam int PROD_W  = atr_pkg::ATR_W + PW;
	localparam int DIVA_W  = SUM_W + FRACTION_BITS;
	localparam int DIVB_W  = ((PROD_W > SRC_W) ? PROD_W : SRC_W) + 1;
	localparam int DIV_W   = (DIVA_W > DIVB_W) ? DIVA_W : DIVB_W;
	localparam int CNT_W   = $clog2(DIV_W);
	localparam int NL_W    = atr_pkg::NLOSS_W;
	localparam int CALC_W  = ((SRC_W > NL_W) ? SRC_W : NL_W) + 2;
	localparam int STOP_W  = atr_pkg::STOP_W;
	localparam int ATR_W   = atr_pkg::ATR_W;
	localparam logic signed [CALC_W-1:0] SMAX =
		$signed({{(CALC_W-STOP_W+1){1'b0}}, {(STOP_W-1){1'b1}}});
	localparam logic signed [CALC_W-1:0] SMIN =
		$signed({{(CALC_W-STOP_W+1){1'b1}}, {(STOP_W-1){1'b0}}});

	logic [PRICE_BITS-1:0]    open_q, high_q, low_q, close_q;
	logic [PRICE_BITS-1:0]    prev_close_q;
	logic [PW-1:0]            bars_q;
	logic [SUM_W-1:0]         sum_q;
	logic [ATR_W-1:0]         atr_q;
	logic signed [STOP_W-1:0] stop_q;
	logic [SRC_W-1:0]         psrc_q;
	logic                     ready_q;
	logic                     init_q;

	logic [SRC_W-1:0]         src_s1;
	logic [PRICE_BITS-1:0]    tr_q;
	logic [PROD_W-1:0]        prod_q;
	logic [DIV_W-1:0]         dvd_q;
	logic [PW-1:0]            rem_q;
	logic [CNT_W-1:0]         cnt_q;
	logic [NL_W-1:0]          nloss_q;

	logic signed [STOP_W-1:0] out_stop_q;
	logic [ATR_W-1:0]         out_atr_q;
	logic                     out_valid_flag_q, out_buy_q, out_sell_q, out_above_q, out_below_q;

	logic [PW-1:0]            period_eff;
	logic [PW-1:0]            bars_inc;
	logic                     first_bar;
	logic                     init_now;
	logic [PRICE_BITS-1:0]    d_hl, d_hp, d_lp, tr_c;
	logic [PRICE_BITS+1:0]    sum4;
	logic [SRC_W-1:0]         src_c;
	logic [PW:0]              trial;
	logic                     ge;

	logic signed [CALC_W-1:0] src_w, nl_w, prev_w, psrc_w, up_w, dn_w, raw_w, stop_w;
	logic                     active;

	assign period_eff = (period_len == '0) ? PW'(1) : period_len;
	assign bars_inc   = (bars_q == '1) ? bars_q : bars_q + 1'b1;
	assign first_bar  = !ready_q && (bars_q == '0);
	assign init_now   = !ready_q && (bars_inc >= period_eff);

	always_comb begin
		d_hl = (high_q > low_q) ? high_q - low_q : low_q - high_q;
		d_hp = (high_q > prev_close_q) ? high_q - prev_close_q : prev_close_q - high_q;
		d_lp = (low_q > prev_close_q) ? low_q - prev_close_q : prev_close_q - low_q;
		tr_c = d_hl;
		if (!first_bar) begin
			if (d_hp > tr_c) tr_c = d_hp;
			if (d_lp > tr_c) tr_c = d_lp;
		end
		sum4 = (PRICE_BITS+2)'(open_q) + (PRICE_BITS+2)'(high_q)
			+ (PRICE_BITS+2)'(low_q) + (PRICE_BITS+2)'(close_q);
		if (averaged_candle_mode) begin
			src_c = SRC_W'(sum4) << (FRACTION_BITS - 2);
		end else begin
			src_c = SRC_W'(close_q) << FRACTION_BITS;
		end
	end

	assign trial = {rem_q, dvd_q[DIV_W-1]};
	assign ge    = (trial >= {1'b0, period_eff});

	assign status.need_div = ready_q || init_now;
	assign status.div_done = (cnt_q == '0);

	assign active = ready_q || init_q;

	always_comb begin
		src_w  = $signed(CALC_W'(src_s1));
		nl_w   = $signed(CALC_W'(nloss_q));
		prev_w = CALC_W'(stop_q);
		psrc_w = $signed(CALC_W'(psrc_q));
		up_w   = src_w - nl_w;
		dn_w   = src_w + nl_w;
		if (!ready_q) begin
			raw_w = up_w;
		end else if (src_w > prev_w && psrc_w > prev_w) begin
			raw_w = (up_w > prev_w) ? up_w : prev_w;
		end else if (src_w < prev_w && psrc_w < prev_w) begin
			raw_w = (dn_w < prev_w) ? dn_w : prev_w;
		end else if (src_w > prev_w) begin
			raw_w = up_w;
		end else begin
			raw_w = dn_w;
		end
		if (raw_w > SMAX) begin
			stop_w = SMAX;
		end else if (raw_w < SMIN) begin
			stop_w = SMIN;
		end else begin
			stop_w = raw_w;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_close_q <= '0;
			bars_q       <= '0;
			sum_q        <= '0;
			atr_q        <= '0;
			stop_q       <= '0;
			psrc_q       <= '0;
			ready_q      <= 1'b0;
			init_q       <= 1'b0;
		end else begin
			if (cmd.prep) begin
				prev_close_q <= close_q;
				init_q       <= init_now;
				if (!ready_q) begin
					sum_q  <= sum_q + SUM_W'(tr_c);
					bars_q <= init_now ? period_eff : bars_inc;
				end
			end
			if (cmd.atr) begin
				atr_q <= (|dvd_q[DIV_W-1:ATR_W]) ? '1 : dvd_q[ATR_W-1:0];
			end
			if (cmd.stop) begin
				psrc_q <= src_s1;
				if (active) begin
					stop_q  <= stop_w[STOP_W-1:0];
					ready_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			open_q  <= open_price;
			high_q  <= high_price;
			low_q   <= low_price;
			close_q <= close_price;
		end
		if (cmd.prep) begin
			src_s1 <= src_c;
			tr_q   <= tr_c;
			prod_q <= PROD_W'(atr_q) * PROD_W'(period_eff - 1'b1);
		end
		if (cmd.load) begin
			if (ready_q) begin
				dvd_q <= DIV_W'(prod_q) + (DIV_W'(tr_q) << FRACTION_BITS);
			end else begin
				dvd_q <= DIV_W'(sum_q) << FRACTION_BITS;
			end
			rem_q <= '0;
			cnt_q <= CNT_W'(DIV_W - 1);
		end
		if (cmd.div_step) begin
			rem_q <= ge ? PW'(trial - {1'b0, period_eff}) : trial[PW-1:0];
			dvd_q <= {dvd_q[DIV_W-2:0], ge};
			cnt_q <= cnt_q - 1'b1;
		end
		if (cmd.nloss) begin
			nloss_q <= NL_W'(atr_q) * NL_W'(atr_multiplier);
		end
		if (cmd.stop) begin
			if (active) begin
				out_stop_q       <= stop_w[STOP_W-1:0];
				out_atr_q        <= atr_q;
				out_valid_flag_q <= 1'b1;
				out_buy_q        <= ready_q && (src_w > stop_w) && (psrc_w <= prev_w);
				out_sell_q       <= ready_q && (src_w < stop_w) && (psrc_w >= prev_w);
				out_above_q      <= (src_w > stop_w);
				out_below_q      <= (src_w < stop_w);
			end else begin
				out_stop_q       <= '0;
				out_atr_q        <= '0;
				out_valid_flag_q <= 1'b0;
				out_buy_q        <= 1'b0;
				out_sell_q       <= 1'b0;
				out_above_q      <= 1'b0;
				out_below_q      <= 1'b0;
			end
		end
	end

	assign stop_level    = out_stop_q;
	assign range_average = out_atr_q;
	assign stop_valid    = out_valid_flag_q;
	assign buy_cross     = out_buy_q;
	assign sell_cross    = out_sell_q;
	assign price_above   = out_above_q;
	assign price_below   = out_below_q;

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

	localparam int PB = atr_pkg::PRICE_BITS_DEF;
	localparam int FB = atr_pkg::FRACTION_BITS_DEF;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN_CYCLES = 60;
	localparam int PHASE_BARS = 170;
	localparam longint PRICE_MAX = (longint'(1) << PB) - 1;
	localparam longint ATR_MAX = (longint'(1) << atr_pkg::ATR_W) - 1;
	localparam longint STOP_HI = (longint'(1) << (atr_pkg::STOP_W - 1)) - 1;
	localparam longint STOP_LO = -(longint'(1) << (atr_pkg::STOP_W - 1));

	typedef struct packed {
		logic [atr_pkg::STOP_W-1:0] stop;
		logic [atr_pkg::ATR_W-1:0]  atr;
		logic                       valid;
		logic                       buy;
		logic                       sell;
		logic                       above;
		logic                       below;
	} bar_result_t;

	logic                              clk = 1'b0;
	logic                              arst_n = 1'b1;
	logic                              psel = 1'b0;
	logic                              penable = 1'b0;
	logic                              pwrite = 1'b0;
	logic [atr_pkg::ADDR_W-1:0]        paddr = '0;
	logic [atr_pkg::DATA_W-1:0]        pwdata = '0;
	logic [atr_pkg::DATA_W-1:0]        prdata;
	logic                              pready;
	logic                              in_valid = 1'b0;
	logic                              in_stall;
	logic [PB-1:0]                     open_price = '0;
	logic [PB-1:0]                     high_price = '0;
	logic [PB-1:0]                     low_price = '0;
	logic [PB-1:0]                     close_price = '0;
	logic                              out_valid;
	logic                              out_stall = 1'b0;
	logic signed [atr_pkg::STOP_W-1:0] stop_level;
	logic [atr_pkg::ATR_W-1:0]         range_average;
	logic                              stop_valid;
	logic                              buy_cross;
	logic                              sell_cross;
	logic                              price_above;
	logic                              price_below;

	atr_trailing_stop_signal dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.open_price    (open_price),
		.high_price    (high_price),
		.low_price     (low_price),
		.close_price   (close_price),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.stop_level    (stop_level),
		.range_average (range_average),
		.stop_valid    (stop_valid),
		.buy_cross     (buy_cross),
		.sell_cross    (sell_cross),
		.price_above   (price_above),
		.price_below   (price_below)
	);

	always #6 clk = ~clk;

	logic [atr_pkg::MULT_W-1:0]   cfg_mult = atr_pkg::MULT_RESET;
	logic [atr_pkg::PERIOD_W-1:0] cfg_period = atr_pkg::PERIOD_RESET;
	logic                         cfg_avg = 1'b0;

	longint last_close = 0;
	longint bars_count = 0;
	longint tr_sum = 0;
	longint atr_now = 0;
	longint stop_now = 0;
	longint last_src = 0;
	bit     stop_armed = 1'b0;

	bar_result_t expected_words[$];
	int          errors = 0;
	int          cycle_count = 0;
	bit          idle_on = 1'b1;
	int          gap_left = 0;
	bit          offering = 1'b0;
	int          wait_left = 0;
	bit          hold_go = 1'b0;
	bit          hold_on = 1'b0;
	longint      walk_price = 0;
	longint      walk_scale = 1;

	function automatic longint abs_gap(input longint a, input longint b);
		return a > b ? a - b : b - a;
	endfunction

	function automatic longint sat_stop(input longint v);
		if (v > STOP_HI) return STOP_HI;
		if (v < STOP_LO) return STOP_LO;
		return v;
	endfunction

	function automatic longint sat_atr(input longint v);
		return v > ATR_MAX ? ATR_MAX : v;
	endfunction

	function automatic void predict_bar(input longint o, input longint h, input longint l,
			input longint c);
		longint      per;
		longint      src;
		longint      tr;
		longint      nloss;
		longint      cand;
		longint      stop;
		bit          first_bar;
		bar_result_t r;
		r = '0;
		per = (cfg_period == 0) ? 1 : longint'(cfg_period);
		first_bar = !stop_armed && bars_count == 0;
		src = cfg_avg ? (o + h + l + c) << (FB - 2) : c << FB;
		tr = abs_gap(h, l);
		if (!first_bar) begin
			if (abs_gap(h, last_close) > tr) tr = abs_gap(h, last_close);
			if (abs_gap(l, last_close) > tr) tr = abs_gap(l, last_close);
		end
		last_close = c;
		if (!stop_armed) begin
			tr_sum = (tr_sum + tr) & 64'hFFFF_FFFF_FFFF;
			if (bars_count < 255) bars_count++;
			if (bars_count >= per) begin
				atr_now = sat_atr((tr_sum << FB) / per);
				stop_now = sat_stop(src - longint'(cfg_mult) * atr_now);
				stop_armed = 1'b1;
				bars_count = per;
				r.stop = stop_now[atr_pkg::STOP_W-1:0];
				r.atr = atr_now[atr_pkg::ATR_W-1:0];
				r.valid = 1'b1;
				r.above = src > stop_now;
				r.below = src < stop_now;
			end
			last_src = src;
		end else begin
			atr_now = sat_atr((atr_now * (per - 1) + (tr << FB)) / per);
			nloss = longint'(cfg_mult) * atr_now;
			if (src > stop_now && last_src > stop_now) begin
				cand = src - nloss;
				stop = cand > stop_now ? cand : stop_now;
			end else if (src < stop_now && last_src < stop_now) begin
				cand = src + nloss;
				stop = cand < stop_now ? cand : stop_now;
			end else if (src > stop_now) begin
				stop = src - nloss;
			end else begin
				stop = src + nloss;
			end
			stop = sat_stop(stop);
			r.stop = stop[atr_pkg::STOP_W-1:0];
			r.atr = atr_now[atr_pkg::ATR_W-1:0];
			r.valid = 1'b1;
			r.buy = src > stop && last_src <= stop_now;
			r.sell = src < stop && last_src >= stop_now;
			r.above = src > stop;
			r.below = src < stop;
			stop_now = stop;
			last_src = src;
		end
		expected_words = {expected_words, r};
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("mismatch %s: got %0h want %0h (cycle %0d)", what, got, want, cycle_count);
		errors++;
	endtask

	task automatic check_word();
		bar_result_t want;
		if (expected_words.size() == 0) begin
			report_mismatch("unexpected word, stop_level", stop_level, 0);
			return;
		end
		want = expected_words.pop_front();
		if (stop_level !== want.stop) report_mismatch("stop_level", stop_level, want.stop);
		if (range_average !== want.atr) report_mismatch("range_average", range_average, want.atr);
		if (stop_valid !== want.valid) report_mismatch("stop_valid", stop_valid, want.valid);
		if (buy_cross !== want.buy) report_mismatch("buy_cross", buy_cross, want.buy);
		if (sell_cross !== want.sell) report_mismatch("sell_cross", sell_cross, want.sell);
		if (price_above !== want.above) report_mismatch("price_above", price_above, want.above);
		if (price_below !== want.below) report_mismatch("price_below", price_below, want.below);
	endtask

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			check_word();
			wait_left = idle_on ? $urandom_range(0, 5) : 0;
		end else if (out_valid && out_stall && wait_left > 0) begin
			wait_left--;
		end
	end

	always @(negedge clk) begin
		out_stall <= hold_on || (wait_left != 0);
	end

	// long receiver hold-off, counted here so the sender keeps pushing meanwhile
	initial begin
		forever begin
			@(posedge hold_go);
			@(posedge clk);
			hold_on = 1'b1;
			repeat (HOLD_CYCLES) @(posedge clk);
			hold_on = 1'b0;
		end
	end

	task automatic send_bar(input longint o, input longint h, input longint l, input longint c);
		repeat (gap_left) @(negedge clk);
		open_price <= o[PB-1:0];
		high_price <= h[PB-1:0];
		low_price <= l[PB-1:0];
		close_price <= c[PB-1:0];
		in_valid <= 1'b1;
		offering = 1'b1;
		do @(posedge clk); while (in_stall);
		predict_bar(o, h, l, c);
		@(negedge clk);
		gap_left = idle_on ? $urandom_range(0, 5) : 0;
		if (gap_left > 0) begin
			in_valid <= 1'b0;
			offering = 1'b0;
		end
	endtask

	task automatic settle();
		if (offering) begin
			in_valid <= 1'b0;
			offering = 1'b0;
		end
		while (expected_words.size() != 0) @(posedge clk);
		@(negedge clk);
		gap_left = 0;
	endtask

	task automatic write_reg(input logic [atr_pkg::IDX_W-1:0] idx,
			input logic [atr_pkg::DATA_W-1:0] value);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			atr_pkg::REG_MULT: cfg_mult = value[atr_pkg::MULT_W-1:0];
			atr_pkg::REG_PERIOD: cfg_period = value[atr_pkg::PERIOD_W-1:0];
			atr_pkg::REG_AVG: cfg_avg = value[0];
			default: ;
		endcase
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
	endtask

	task automatic set_config(input int mult, input int period, input int avg);
		write_reg(atr_pkg::REG_MULT, mult);
		write_reg(atr_pkg::REG_PERIOD, period);
		write_reg(atr_pkg::REG_AVG, avg);
	endtask

	task automatic random_bar();
		longint o;
		longint h;
		longint l;
		longint c;
		if ($urandom_range(0, 9) == 0) begin
			o = longint'($urandom()) & PRICE_MAX;
			h = longint'($urandom()) & PRICE_MAX;
			l = longint'($urandom()) & PRICE_MAX;
			c = longint'($urandom()) & PRICE_MAX;
		end else begin
			o = walk_price;
			walk_price += longint'($urandom_range(0, 2 * walk_scale)) - walk_scale;
			if (walk_price < 0) walk_price = 0;
			if (walk_price > PRICE_MAX) walk_price = PRICE_MAX;
			c = walk_price;
			h = (o > c ? o : c) + longint'($urandom_range(0, walk_scale));
			l = (o < c ? o : c) - longint'($urandom_range(0, walk_scale));
			if (h > PRICE_MAX) h = PRICE_MAX;
			if (l < 0) l = 0;
		end
		send_bar(o, h, l, c);
	endtask

	task automatic run_phase(input int mult, input int period, input int avg, input int bars);
		set_config(mult, period, avg);
		walk_scale = longint'(1) << $urandom_range(0, 18);
		walk_price = longint'($urandom()) & PRICE_MAX;
		repeat (bars) random_bar();
		settle();
	endtask

	task automatic test_warmup_defaults();
		send_bar(0, 100, 5000, 300);
		send_bar(0, 0, 0, 0);
		send_bar(PRICE_MAX, PRICE_MAX, PRICE_MAX, PRICE_MAX);
		send_bar(PRICE_MAX, PRICE_MAX, 0, 0);
		settle();
	endtask

	task automatic test_period_change_in_warmup();
		write_reg(atr_pkg::REG_PERIOD, 255);
		send_bar(0, PRICE_MAX, 0, PRICE_MAX);
		send_bar(PRICE_MAX, PRICE_MAX, 0, 0);
		send_bar(0, 0, PRICE_MAX, PRICE_MAX);
		send_bar(PRICE_MAX, 0, PRICE_MAX, 0);
		settle();
		write_reg(atr_pkg::REG_PERIOD, 2);
		send_bar(PRICE_MAX, PRICE_MAX, 0, PRICE_MAX);
		send_bar(1000, 2000, 500, 1500);
		send_bar(1500, 1600, 1400, 1500);
		settle();
	endtask

	task automatic test_zero_period_max_mult();
		set_config(15, 0, 1);
		send_bar(123456, 200000, 100000, 150000);
		send_bar(150000, 90000, 250000, 240000);
		send_bar(PRICE_MAX, PRICE_MAX, PRICE_MAX - 3, PRICE_MAX - 1);
		settle();
	endtask

	task automatic test_flat_crossings();
		set_config(1, 1, 0);
		send_bar(1000, 1000, 1000, 1000);
		send_bar(1000, 1000, 1000, 1000);
		send_bar(5000, 5000, 5000, 5000);
		send_bar(5000, 5000, 5000, 5000);
		send_bar(1000, 1000, 1000, 1000);
		send_bar(1000, 1000, 1000, 1000);
		send_bar(0, 0, 0, 0);
		settle();
		set_config(0, 1, 0);
		send_bar(700, 700, 700, 700);
		send_bar(700, 700, 700, 700);
		settle();
	endtask

	task automatic test_random_extremes();
		run_phase(0, 1, 0, PHASE_BARS);
		run_phase(15, 255, 1, PHASE_BARS);
		run_phase(1, 1, 1, PHASE_BARS);
		run_phase(2, 255, 0, PHASE_BARS);
	endtask

	task automatic test_random_settings();
		repeat (4) begin
			run_phase($urandom_range(0, 15), $urandom_range(0, 255), $urandom_range(0, 1),
				PHASE_BARS);
		end
	endtask

	task automatic test_no_idle();
		idle_on = 1'b0;
		run_phase($urandom_range(1, 4), $urandom_range(1, 20), $urandom_range(0, 1), 100);
		idle_on = 1'b1;
	endtask

	task automatic test_output_hold();
		set_config($urandom_range(1, 3), $urandom_range(1, 14), $urandom_range(0, 1));
		hold_go = 1'b1;
		repeat (40) random_bar();
		hold_go = 1'b0;
		settle();
	endtask

	initial begin
		arst_n <= 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_warmup_defaults();
		test_period_change_in_warmup();
		test_zero_period_max_mult();
		test_flat_crossings();
		test_random_extremes();
		test_random_settings();
		test_no_idle();
		test_output_hold();
		while (expected_words.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
